// ----- rtl/res_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// res_pkg: shared types and constants of the relative error integral servo
//
// Field widths, register indexes, status codes, controller states and the
// fixed-point constants of the servo loop.
// ----------------------------------------------------------------------------
package res_pkg;

    // Field widths.
    localparam int VAL_W   = 16;
    localparam int STAT_W  = 3;
    localparam int IDX_W   = 3;
    localparam int LIM_W   = 8;
    localparam int MATCH_W = 2;

    // Divider: numerator is |diff| (16 bits) scaled by 2^14.
    localparam int ERR_FRAC  = 14;
    localparam int QUO_W     = VAL_W + ERR_FRAC;
    localparam int DIV_CNT_W = $clog2(QUO_W + 1);

    // Serial multiplier: one multiplier bit per cycle.
    localparam int MUL_CNT_W = $clog2(VAL_W);
    localparam int PROD_W    = 2 * VAL_W;
    localparam int MUL_ACC_W = VAL_W + 2;

    // Drive step: product of Q8.8 gain and Q2.14 error, scaled to Q10.12.
    localparam int STEP_SHIFT = 10;
    localparam int STEP_W     = PROD_W - STEP_SHIFT;
    localparam int SUM_W      = STEP_W + 1;
    localparam logic signed [STEP_W-1:0] STEP_CAP = STEP_W'(205);

    localparam logic [MATCH_W-1:0] REQUIRED_MATCHES = MATCH_W'(3);
    localparam logic [MATCH_W-1:0] MATCH_MAX        = MATCH_W'(3);
    localparam logic [LIM_W-1:0]   ATTEMPT_MAX      = LIM_W'(255);

    localparam logic signed [VAL_W-1:0] ERR_POS_SAT = 16'sh7FFF;
    localparam logic signed [VAL_W-1:0] ERR_NEG_SAT = 16'sh8000;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_SET_POINT     = 3'd0,
        REG_TOLERANCE     = 3'd1,
        REG_LOOP_GAIN     = 3'd2,
        REG_DRIVE_MIN     = 3'd3,
        REG_DRIVE_MAX     = 3'd4,
        REG_MONITOR_ONLY  = 3'd5,
        REG_ATTEMPT_LIMIT = 3'd6
    } reg_idx_t;

    // Request kinds.
    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_IDLE      = 3'd0,
        STAT_RUNNING   = 3'd1,
        STAT_CONVERGED = 3'd2,
        STAT_FAILED    = 3'd3,
        STAT_MON_OK    = 3'd4,
        STAT_MON_DRIFT = 3'd5
    } status_t;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_EVAL = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } fsm_t;

endpackage

// ----- rtl/res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// res_if: handshake channels of the relative error integral servo
//
// Request, response and configuration write channels, each with valid and
// ready; a beat moves when both are high at a rising clock edge.
// ----------------------------------------------------------------------------
interface res_req_if;
    import res_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic signed [VAL_W-1:0] initial_drive;
    logic signed [VAL_W-1:0] measured_value;

    modport source (output valid, output req_type, output initial_drive,
                    output measured_value, input ready);
    modport sink   (input valid, input req_type, input initial_drive,
                    input measured_value, output ready);
endinterface

interface res_rsp_if;
    import res_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] drive_out;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] relative_error;

    modport source (output valid, output drive_out, output status,
                    output relative_error, input ready);
    modport sink   (input valid, input drive_out, input status,
                    input relative_error, output ready);
endinterface

interface res_cfg_if;
    import res_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/res_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// res_div: bit-serial restoring divider
//
// Divides (num << 14) by den, both unsigned, one quotient bit per cycle.
// done pulses for one cycle when quo holds the result.
// ----------------------------------------------------------------------------
module res_div
    import res_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [VAL_W-1:0] num,
    input  logic [VAL_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [QUO_W-1:0]     num_reg, num_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [VAL_W-1:0]     rem_reg, rem_next;
    logic [VAL_W-1:0]     den_reg, den_next;
    logic [VAL_W-1:0]     trial;
    logic                 fits;

    // The remainder stays below den, so its top bit is free for the shift.
    assign trial = {rem_reg[VAL_W-2:0], num_reg[QUO_W-1]};
    assign fits  = (trial >= den_reg);

    // One restoring step per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = {num, {ERR_FRAC{1'b0}}};
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[QUO_W-2:0], 1'b0};
            quo_next = {quo_reg[QUO_W-2:0], fits};
            rem_next = fits ? (trial - den_reg) : trial;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- rtl/res_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// res_mul: bit-serial signed multiplier
//
// Shift-add multiplication of two signed 16-bit values, one multiplier bit
// per cycle; the sign bit of the multiplier subtracts. done pulses for one
// cycle when prod holds the 32-bit product.
// ----------------------------------------------------------------------------
module res_mul
    import res_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [VAL_W-1:0]  mcand,
    input  logic signed [VAL_W-1:0]  mplier,
    output logic                     done,
    output logic signed [PROD_W-1:0] prod
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [MUL_CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [MUL_ACC_W-1:0] hi_reg, hi_next;
    logic [VAL_W-1:0]            lo_reg, lo_next;
    logic signed [MUL_ACC_W-1:0] mc_reg, mc_next;
    logic signed [MUL_ACC_W-1:0] addend;
    logic signed [MUL_ACC_W-1:0] sum;
    logic                        last;

    assign last = (cnt_reg == MUL_CNT_W'(VAL_W - 1));

    // Add or subtract the multiplicand for the current multiplier bit.
    always_comb
    begin
        if (!lo_reg[0])
        begin
            addend = '0;
        end
        else if (last)
        begin
            addend = -mc_reg;
        end
        else
        begin
            addend = mc_reg;
        end
        sum = hi_reg + addend;
    end

    // Shift the partial product right by one bit each cycle.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        mc_next   = mc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            hi_next   = '0;
            lo_next   = mplier;
            mc_next   = MUL_ACC_W'(mcand);
        end
        else if (busy_reg)
        begin
            hi_next  = {sum[MUL_ACC_W-1], sum[MUL_ACC_W-1:1]};
            lo_next  = {sum[0], lo_reg[VAL_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        mc_reg <= mc_next;
    end

    assign done = done_reg;
    assign prod = {hi_reg[VAL_W-1:0], lo_reg};

endmodule

// ----- rtl/relative_error_integral_servo.sv -----
`timescale 1ns / 1ps
// A start beat, or a sample while the servo is idle, goes straight to the response; a sample
// in a running servo passes the serial divider, and the serial multiplier too when the drive
// moves; a zero set point skips the divider. One beat is processed at a time, so a new beat
// is taken in the cycle after the result is loaded, and a response not yet taken holds the
// next result back. Reset restores the default registers and stops the servo.
// ----------------------------------------------------------------------------
// relative_error_integral_servo: integral servo with settle detection
//
// Forms the relative error of each sample against the set point, counts consecutive
// in-tolerance samples, and otherwise steps the drive by the loop gain times the error,
// with an upper step cap and a drive clamp; monitor-only mode just reports drift.
// ----------------------------------------------------------------------------
module relative_error_integral_servo
    import res_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    res_req_if.sink    req,
    res_rsp_if.source  rsp,
    res_cfg_if.sink    cfg
);

    // Configuration registers.
    logic signed [VAL_W-1:0] set_point_reg;
    logic [VAL_W-1:0]        tolerance_reg;
    logic signed [VAL_W-1:0] loop_gain_reg;
    logic signed [VAL_W-1:0] drive_min_reg;
    logic signed [VAL_W-1:0] drive_max_reg;
    logic                    monitor_only_reg;
    logic [LIM_W-1:0]        attempt_limit_reg;

    // Servo state.
    fsm_t                    state_reg, state_next;
    logic signed [VAL_W-1:0] drive_reg, drive_next;
    logic [MATCH_W-1:0]      match_reg, match_next;
    logic [LIM_W-1:0]        attempt_reg, attempt_next;
    logic                    running_reg, running_next;

    // Working registers of one beat.
    logic                    diff_neg_reg, diff_neg_next;
    logic signed [VAL_W-1:0] err_reg, err_next;
    logic signed [VAL_W-1:0] st_drive_reg, st_drive_next;
    status_t                 st_status_reg, st_status_next;
    logic signed [VAL_W-1:0] st_err_reg, st_err_next;

    // Output register.
    logic                    out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0] out_drive_reg;
    logic [STAT_W-1:0]       out_status_reg;
    logic signed [VAL_W-1:0] out_err_reg;
    logic                    out_load;

    // Arithmetic units.
    logic                     div_start, div_done;
    logic [VAL_W-1:0]         div_num, div_den;
    logic [QUO_W-1:0]         div_quo;
    logic                     mul_start, mul_done;
    logic signed [PROD_W-1:0] mul_prod;

    // Combinational helpers.
    logic signed [VAL_W:0]    diff;
    logic [VAL_W-1:0]         abs_diff;
    logic signed [VAL_W:0]    sp_ext;
    logic [VAL_W-1:0]         sp_mag;
    logic signed [VAL_W-1:0]  err_sat;
    logic [VAL_W:0]           err_mag;
    logic                     in_tol;
    logic [LIM_W-1:0]         lim;
    logic [LIM_W-1:0]         att_inc;
    logic [MATCH_W-1:0]       match_inc;
    logic signed [STEP_W-1:0] step_raw;
    logic signed [STEP_W-1:0] step_capped;
    logic signed [SUM_W-1:0]  drive_sum;
    logic signed [VAL_W-1:0]  drive_stepped;
    logic signed [VAL_W-1:0]  drive_start;

    // Clamp to the drive range; when the range is empty, values below the lower bound take it and all others the upper.
    function automatic logic signed [VAL_W-1:0] clamp_drive(
        input logic signed [SUM_W-1:0] v,
        input logic signed [VAL_W-1:0] lo,
        input logic signed [VAL_W-1:0] hi
    );
        logic signed [VAL_W-1:0] r;
        if (v < SUM_W'(lo))
        begin
            r = lo;
        end
        else if (v > SUM_W'(hi))
        begin
            r = hi;
        end
        else
        begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    // Configuration writes; indexes beyond the list are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_point_reg     <= 16'sd4096;
            tolerance_reg     <= 16'd655;
            loop_gain_reg     <= 16'sd256;
            drive_min_reg     <= 16'sh8000;
            drive_max_reg     <= 16'sh7FFF;
            monitor_only_reg  <= 1'b0;
            attempt_limit_reg <= 8'd100;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SET_POINT:     set_point_reg     <= cfg.data;
                REG_TOLERANCE:     tolerance_reg     <= cfg.data;
                REG_LOOP_GAIN:     loop_gain_reg     <= cfg.data;
                REG_DRIVE_MIN:     drive_min_reg     <= cfg.data;
                REG_DRIVE_MAX:     drive_max_reg     <= cfg.data;
                REG_MONITOR_ONLY:  monitor_only_reg  <= cfg.data[0];
                REG_ATTEMPT_LIMIT: attempt_limit_reg <= cfg.data[LIM_W-1:0];
                default:           ;
            endcase
        end
    end

    // Difference and set point magnitude for the divider.
    always_comb
    begin
        sp_ext   = {set_point_reg[VAL_W-1], set_point_reg};
        diff     = sp_ext - {req.measured_value[VAL_W-1], req.measured_value};
        abs_diff = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
        sp_mag   = set_point_reg[VAL_W-1] ? VAL_W'(-sp_ext) : set_point_reg;
    end

    assign div_num = abs_diff;
    assign div_den = sp_mag;

    // Saturate and sign the quotient.
    always_comb
    begin
        if (diff_neg_reg)
        begin
            if (div_quo > QUO_W'(32768))
            begin
                err_sat = ERR_NEG_SAT;
            end
            else
            begin
                err_sat = VAL_W'(-div_quo[VAL_W:0]);
            end
        end
        else
        begin
            if (div_quo > QUO_W'(32767))
            begin
                err_sat = ERR_POS_SAT;
            end
            else
            begin
                err_sat = div_quo[VAL_W-1:0];
            end
        end
    end

    // Tolerance test and counter increments.
    always_comb
    begin
        err_mag   = err_reg[VAL_W-1] ? (VAL_W+1)'(-{err_reg[VAL_W-1], err_reg})
                                     : (VAL_W+1)'(err_reg);
        in_tol    = ({err_mag, 2'b00} < (VAL_W+3)'(tolerance_reg));
        lim       = (attempt_limit_reg == '0) ? LIM_W'(1) : attempt_limit_reg;
        att_inc   = (attempt_reg == ATTEMPT_MAX) ? attempt_reg : attempt_reg + 1'b1;
        match_inc = (match_reg == MATCH_MAX) ? match_reg : match_reg + 1'b1;
    end

    // Drive step from the product: floor divide by 2^10 and cap above.
    always_comb
    begin
        step_raw      = mul_prod[PROD_W-1:STEP_SHIFT];
        step_capped   = (step_raw > STEP_CAP) ? STEP_CAP : step_raw;
        drive_sum     = SUM_W'(drive_reg) + SUM_W'(step_capped);
        drive_stepped = clamp_drive(drive_sum, drive_min_reg, drive_max_reg);
        drive_start   = clamp_drive(SUM_W'(req.initial_drive),
                                    drive_min_reg, drive_max_reg);
    end

    assign req.ready = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        drive_next     = drive_reg;
        match_next     = match_reg;
        attempt_next   = attempt_reg;
        running_next   = running_reg;
        diff_neg_next  = diff_neg_reg;
        err_next       = err_reg;
        st_drive_next  = st_drive_reg;
        st_status_next = st_status_reg;
        st_err_next    = st_err_reg;
        div_start      = 1'b0;
        mul_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.req_type == REQ_START)
                    begin
                        drive_next     = drive_start;
                        match_next     = '0;
                        attempt_next   = '0;
                        running_next   = 1'b1;
                        st_drive_next  = drive_start;
                        st_status_next = STAT_RUNNING;
                        st_err_next    = '0;
                        state_next     = S_DONE;
                    end
                    else if (!running_reg)
                    begin
                        st_drive_next  = drive_reg;
                        st_status_next = STAT_IDLE;
                        st_err_next    = '0;
                        state_next     = S_DONE;
                    end
                    else if (sp_mag == '0)
                    begin
                        // Zero set point: the error goes straight to its limit, or to zero when the sample is zero too.
                        if (diff[VAL_W])
                        begin
                            err_next = ERR_NEG_SAT;
                        end
                        else if (diff != '0)
                        begin
                            err_next = ERR_POS_SAT;
                        end
                        else
                        begin
                            err_next = '0;
                        end
                        state_next = S_EVAL;
                    end
                    else
                    begin
                        diff_neg_next = diff[VAL_W];
                        div_start     = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    err_next   = err_sat;
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                st_drive_next = drive_reg;
                st_err_next   = err_reg;
                if (monitor_only_reg)
                begin
                    running_next   = 1'b0;
                    st_status_next = in_tol ? STAT_MON_OK : STAT_MON_DRIFT;
                    state_next     = S_DONE;
                end
                else if (in_tol)
                begin
                    attempt_next = att_inc;
                    match_next   = match_inc;
                    if (match_inc >= REQUIRED_MATCHES)
                    begin
                        running_next   = 1'b0;
                        st_status_next = STAT_CONVERGED;
                    end
                    else if (att_inc >= lim)
                    begin
                        running_next   = 1'b0;
                        st_status_next = STAT_FAILED;
                    end
                    else
                    begin
                        st_status_next = STAT_RUNNING;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    attempt_next = att_inc;
                    match_next   = '0;
                    mul_start    = 1'b1;
                    state_next   = S_MUL;
                end
            end

            S_MUL:
            begin
                if (mul_done)
                begin
                    drive_next    = drive_stepped;
                    st_drive_next = drive_stepped;
                    if (attempt_reg >= lim)
                    begin
                        running_next   = 1'b0;
                        st_status_next = STAT_FAILED;
                    end
                    else
                    begin
                        st_status_next = STAT_RUNNING;
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            drive_reg     <= '0;
            match_reg     <= '0;
            attempt_reg   <= '0;
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            drive_reg     <= drive_next;
            match_reg     <= match_next;
            attempt_reg   <= attempt_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        diff_neg_reg  <= diff_neg_next;
        err_reg       <= err_next;
        st_drive_reg  <= st_drive_next;
        st_status_reg <= st_status_next;
        st_err_reg    <= st_err_next;
        if (out_load)
        begin
            out_drive_reg  <= st_drive_reg;
            out_status_reg <= st_status_reg;
            out_err_reg    <= st_err_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.drive_out      = out_drive_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.relative_error = out_err_reg;

    // Serial divider for the relative error.
    res_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Serial multiplier for the drive step.
    res_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (loop_gain_reg),
        .mplier (err_reg),
        .done   (mul_done),
        .prod   (mul_prod)
    );

endmodule
